FILE: hw/rtl/clsrng_pkg.sv
// Shared constants, payload types and controller states for the combined LCG shuffle generator.
package clsrng_pkg;

	localparam int DEF_TABLE_SIZE   = 32;
	localparam int DEF_WARMUP_STEPS = 8;

	localparam int GEN_W  = 32;
	localparam int OUT_W  = 31;
	localparam int PROD_W = 48;
	localparam int MUL_W  = 16;
	localparam int FOLD_W = 8;

	localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
	localparam logic [MUL_W-1:0] MUL2 = 16'd40692;
	localparam logic [GEN_W-1:0] MOD1 = 32'd2147483563;
	localparam logic [GEN_W-1:0] MOD2 = 32'd2147483399;

	// Each modulus is 2^31 minus a small constant, so 2^31 folds back as that constant.
	localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

	localparam logic [GEN_W-1:0] SEED2_RESET  = 32'd123456789;
	localparam logic [OUT_W-1:0] NEAR_ONE_MIN = 31'd2147483306;

	localparam logic MODE_DRAW = 1'b0;
	localparam logic MODE_SEED = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] seed;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] sample;
		logic             near_one;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_MUL,
		ST_INIT_RED,
		ST_IDX_MUL,
		ST_DRAW_ISSUE,
		ST_DRAW_RED,
		ST_DRAW_OUT
	} state_t;

endpackage

FILE: hw/rtl/combined_lcg_shuffle_rng_core.sv
// Combined LCG with shuffle table: controller, index divider and output register.
// Seed load: taken in ST_IDLE, no result. Draw: taken in ST_IDLE, then ST_DRAW_RED, then
// ST_DRAW_OUT registers the result once the output slot is free; ST_IDX_MUL then forms the
// next index product before the next transaction is taken. A draw that initializes first
// runs the warm-up and table-fill steps (ST_INIT_MUL, ST_INIT_RED) and ST_IDX_MUL. Reset
// (arst_n low) clears fg_q, sets sg_q to SEED2_RESET; the table needs no clearing pass.
module combined_lcg_shuffle_rng_core #(
	parameter int TABLE_SIZE   = clsrng_pkg::DEF_TABLE_SIZE,
	parameter int WARMUP_STEPS = clsrng_pkg::DEF_WARMUP_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  clsrng_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output clsrng_pkg::rsp_t  rsp
);
	import clsrng_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int STEPS = TABLE_SIZE + WARMUP_STEPS;
	localparam int CNT_W = $clog2(STEPS);
	localparam int RCP_W = OUT_W + 2;
	localparam int IP_W  = OUT_W + RCP_W;
	localparam logic [63:0] NDIV  = 64'd1 + (64'(MOD1) - 64'd1) / 64'(TABLE_SIZE);
	localparam int          RSH   = OUT_W + $clog2(NDIV);
	localparam logic [63:0] RECIP = ((64'd1 << RSH) + NDIV - 64'd1) / NDIV;

	state_t            state_q;
	state_t            state_d;
	logic [GEN_W-1:0]  fg_q;
	logic [GEN_W-1:0]  sg_q;
	logic [OUT_W-1:0]  last_out_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              draw_pend_q;
	logic [IP_W-1:0]   idx_prod_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [GEN_W-1:0]  y1;
	logic [GEN_W-1:0]  y2;
	logic [GEN_W-1:0]  g0;
	logic              need_init;
	logic [IP_W-1:0]   q_full;
	logic [IDX_W-1:0]  idx;
	logic [OUT_W-1:0]  entry;
	logic [GEN_W-1:0]  res;
	logic              slot_free;
	logic              tbl_re;
	logic              tbl_we;
	logic [IDX_W-1:0]  tbl_waddr;
	logic [OUT_W-1:0]  tbl_wdata;

	clsrng_lcg u_lcg (
		.clk (clk),
		.x1  (fg_q),
		.x2  (sg_q),
		.y1  (y1),
		.y2  (y2)
	);

	clsrng_tbl #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_tbl (
		.clk   (clk),
		.re    (tbl_re),
		.raddr (idx),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.rdata (entry)
	);

	always_comb begin
		// The most negative seed negates to 2^31, which the first step reduces.
		if (fg_q[GEN_W-1]) begin
			g0 = ~fg_q + GEN_W'(1);
		end else if (fg_q == '0) begin
			g0 = GEN_W'(1);
		end else begin
			g0 = fg_q;
		end
		need_init = fg_q[GEN_W-1] || (fg_q == '0) || (last_out_q == '0);

		// Exact division by NDIV through a reciprocal, valid for all 31-bit values.
		q_full = idx_prod_q >> RSH;
		idx    = (q_full >= IP_W'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1) : q_full[IDX_W-1:0];

		if (GEN_W'(entry) > sg_q) begin
			res = GEN_W'(entry) - sg_q;
		end else begin
			res = GEN_W'(entry) + (MOD1 - GEN_W'(1)) - sg_q;
		end

		slot_free = !rsp_valid_q || rsp_ready;
	end

	always_comb begin
		state_d   = state_q;
		tbl_re    = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = idx;
		tbl_wdata = fg_q[OUT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req.mode == MODE_DRAW) begin
					if (need_init) begin
						state_d = ST_INIT_MUL;
					end else begin
						tbl_re  = 1'b1;
						state_d = ST_DRAW_RED;
					end
				end
			end
			ST_INIT_MUL: begin
				state_d = ST_INIT_RED;
			end
			ST_INIT_RED: begin
				// The table fills from the top entry down during the last TABLE_SIZE steps.
				tbl_we    = GEN_W'(cnt_q) < GEN_W'(TABLE_SIZE);
				tbl_waddr = cnt_q[IDX_W-1:0];
				tbl_wdata = y1[OUT_W-1:0];
				state_d   = (cnt_q == '0) ? ST_IDX_MUL : ST_INIT_MUL;
			end
			ST_IDX_MUL: begin
				state_d = draw_pend_q ? ST_DRAW_ISSUE : ST_IDLE;
			end
			ST_DRAW_ISSUE: begin
				tbl_re  = 1'b1;
				state_d = ST_DRAW_RED;
			end
			ST_DRAW_RED: begin
				state_d = ST_DRAW_OUT;
			end
			ST_DRAW_OUT: begin
				if (slot_free) begin
					tbl_we  = 1'b1;
					state_d = ST_IDX_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fg_q        <= '0;
			sg_q        <= SEED2_RESET;
			last_out_q  <= '0;
			cnt_q       <= '0;
			draw_pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAW_OUT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.mode == MODE_SEED) begin
							fg_q <= GEN_W'(req.seed);
						end else if (need_init) begin
							fg_q  <= g0;
							sg_q  <= g0;
							cnt_q <= CNT_W'(STEPS - 1);
						end
					end
				end
				ST_INIT_RED: begin
					fg_q <= y1;
					if (cnt_q == '0) begin
						last_out_q  <= y1[OUT_W-1:0];
						draw_pend_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_IDX_MUL: begin
					draw_pend_q <= 1'b0;
				end
				ST_DRAW_RED: begin
					fg_q <= y1;
					sg_q <= y2;
				end
				ST_DRAW_OUT: begin
					if (slot_free) begin
						last_out_q <= res[OUT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDX_MUL) begin
			idx_prod_q <= IP_W'(last_out_q) * IP_W'(RECIP[RCP_W-1:0]);
		end
		if (state_q == ST_DRAW_OUT && slot_free) begin
			rsp_q.sample   <= res[OUT_W-1:0];
			rsp_q.near_one <= res[OUT_W-1:0] >= NEAR_ONE_MIN;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_re && tbl_we))
		else $error("table read and write issued in the same cycle");

	a_draw_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_OUT && slot_free) |=> rsp_valid_q)
		else $error("finished draw did not reach the output register");

	a_sg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (sg_q < MOD2))
		else $error("second generator not reduced while idle");

	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (last_out_q < MOD1[OUT_W-1:0]))
		else $error("last output out of range while idle");

	a_rsp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.sample != '0))
		else $error("zero sample in a result transaction");

endmodule

FILE: hw/rtl/clsrng_lcg.sv
// Modular multiply for both generators: registered product, then combinational fold and reduce.
module clsrng_lcg (
	input  logic                          clk,
	input  logic [clsrng_pkg::GEN_W-1:0] x1,
	input  logic [clsrng_pkg::GEN_W-1:0] x2,
	output logic [clsrng_pkg::GEN_W-1:0] y1,
	output logic [clsrng_pkg::GEN_W-1:0] y2
);
	import clsrng_pkg::*;

	localparam int HI_W = PROD_W - OUT_W;
	localparam int FP_W = HI_W + FOLD_W;

	logic [PROD_W-1:0] p1_s1;
	logic [PROD_W-1:0] p2_s1;
	logic [FP_W-1:0]   fold1;
	logic [FP_W-1:0]   fold2;
	logic [GEN_W-1:0]  t1;
	logic [GEN_W-1:0]  t2;

	always_ff @(posedge clk) begin
		p1_s1 <= PROD_W'(x1) * PROD_W'(MUL1);
		p2_s1 <= PROD_W'(x2) * PROD_W'(MUL2);
	end

	// p = hi * 2^31 + lo is congruent to hi * fold + lo, which stays below twice the modulus.
	always_comb begin
		fold1 = FP_W'(p1_s1[PROD_W-1:OUT_W]) * FP_W'(FOLD1);
		fold2 = FP_W'(p2_s1[PROD_W-1:OUT_W]) * FP_W'(FOLD2);
		t1    = GEN_W'(p1_s1[OUT_W-1:0]) + GEN_W'(fold1);
		t2    = GEN_W'(p2_s1[OUT_W-1:0]) + GEN_W'(fold2);
		y1    = (t1 >= MOD1) ? (t1 - MOD1) : t1;
		y2    = (t2 >= MOD2) ? (t2 - MOD2) : t2;
	end

endmodule

FILE: hw/rtl/clsrng_tbl.sv
// Shuffle table memory: one write port and one registered read port.
module clsrng_tbl #(
	parameter int TABLE_SIZE = clsrng_pkg::DEF_TABLE_SIZE
) (
	input  logic                          clk,
	input  logic                          re,
	input  logic [$clog2(TABLE_SIZE)-1:0] raddr,
	input  logic                          we,
	input  logic [$clog2(TABLE_SIZE)-1:0] waddr,
	input  logic [clsrng_pkg::OUT_W-1:0] wdata,
	output logic [clsrng_pkg::OUT_W-1:0] rdata
);
	import clsrng_pkg::*;

	logic [OUT_W-1:0] mem [TABLE_SIZE];
	logic [OUT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

FILE: tb/tb_combined_lcg_shuffle_rng_core.sv
// Self-checking testbench for the combined LCG shuffle generator: bursty requests, stalled responses.
module tb_combined_lcg_shuffle_rng_core;
	import clsrng_pkg::*;

	localparam int           TBL  = DEF_TABLE_SIZE;
	localparam int           WARM = DEF_WARMUP_STEPS;
	localparam longint       NDIV = 1 + (longint'(MOD1) - 1) / TBL;
	localparam int           RANDOM_ITEMS = 1425;

	typedef struct {
		req_t req;
		bit   wait_idle;
	} stim_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	stim_item_t stim_q[$];
	rsp_t       pending_samples[$];

	// Shadow generator state.
	longint     gen1_mdl;
	bit [63:0]  gen2_mdl;
	bit [63:0]  last_mdl;
	bit [63:0]  shuffle_mdl[TBL];

	int mismatches = 0;
	int n_draws_in = 0;
	int n_seeds_in = 0;
	int n_refills = 0;
	int n_samples_out = 0;
	int outstanding = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	logic [31:0] rx_cycle = '0;

	combined_lcg_shuffle_rng_core #(
		.TABLE_SIZE(TBL),
		.WARMUP_STEPS(WARM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic bit [63:0] lcg_advance(input bit [63:0] x, input bit [63:0] mul,
			input bit [63:0] m);
		return (mul * x) % m;
	endfunction

	function automatic void refill_shuffle();
		bit [63:0] g;
		if (gen1_mdl < 0)
			g = -gen1_mdl;
		else if (gen1_mdl == 0)
			g = 64'd1;
		else
			g = gen1_mdl;
		gen2_mdl = g;
		for (int j = TBL + WARM - 1; j >= 0; j--) begin
			g = lcg_advance(g, 64'(MUL1), 64'(MOD1));
			if (j < TBL)
				shuffle_mdl[j] = g;
		end
		gen1_mdl = longint'(g);
		last_mdl = shuffle_mdl[0];
		n_refills++;
	endfunction

	function automatic rsp_t predict_draw();
		bit [63:0] idx;
		bit [63:0] entry;
		bit [63:0] res;
		rsp_t r;
		if (gen1_mdl <= 0 || last_mdl == 0)
			refill_shuffle();
		gen1_mdl = longint'(lcg_advance(gen1_mdl, 64'(MUL1), 64'(MOD1)));
		gen2_mdl = lcg_advance(gen2_mdl, 64'(MUL2), 64'(MOD2));
		idx = last_mdl / NDIV;
		if (idx >= TBL)
			idx = 64'(TBL - 1);
		entry = shuffle_mdl[idx];
		if (entry > gen2_mdl)
			res = entry - gen2_mdl;
		else
			res = entry + 64'(MOD1) - 1 - gen2_mdl;
		shuffle_mdl[idx] = gen1_mdl;
		last_mdl = res;
		r.sample = res[OUT_W-1:0];
		r.near_one = (res >= 64'(NEAR_ONE_MIN));
		return r;
	endfunction

	task automatic add_item(input logic mode, input logic [31:0] seed, input bit wait_idle);
		stim_item_t it;
		it.req.mode = mode;
		it.req.seed = seed;
		it.wait_idle = wait_idle;
		stim_q.push_back(it);
	endtask

	initial begin
		logic [31:0] odd_seeds[6];
		odd_seeds = '{32'h0000_0000, 32'h8000_0000, 32'(MOD1), 32'(MOD2), 32'h7FFF_FFFF,
			32'hFFFF_FFFF};
		gen1_mdl = 0;
		gen2_mdl = 64'(SEED2_RESET);
		last_mdl = '0;
		foreach (shuffle_mdl[i])
			shuffle_mdl[i] = '0;

		// Directed: draws straight from reset, then each awkward seed followed by draws.
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_DRAW, 32'hFFFF_FFFF, 1'b0);
		add_item(MODE_SEED, 32'd0, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_SEED, 32'hFFFF_FFFF, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_SEED, 32'h8000_0000, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		// A seed equal to the first modulus lets the first draw drive that generator to zero, which
		// forces a refill on the second draw.
		add_item(MODE_SEED, 32'(MOD1), 1'b1);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_SEED, 32'(MOD2), 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_SEED, 32'h7FFF_FFFF, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_SEED, 32'h8000_0001, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_SEED, 32'd1, 1'b0);
		// A positive seed after a draw replaces the first generator without a refill.
		add_item(MODE_SEED, 32'd12345, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);
		add_item(MODE_DRAW, 32'd0, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			bit idle_first;
			idle_first = (i % 300 == 150);
			if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 7) == 0)
					add_item(MODE_SEED, odd_seeds[$urandom_range(0, 5)], idle_first);
				else
					add_item(MODE_SEED, $urandom, idle_first);
			end else begin
				add_item(MODE_DRAW, $urandom, idle_first);
			end
		end
	end

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || req_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (stim_q.size() == 0) begin
				req_valid <= 1'b0;
			end else if (stim_q[0].wait_idle &&
					(outstanding != 0 || (req_valid && req.mode == MODE_DRAW))) begin
				req_valid <= 1'b0;
			end else begin
				req_valid <= 1'b1;
				req <= stim_q[0].req;
				void'(stim_q.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Response ready pattern; one long hold-off lets the block back up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (!hold_done && n_samples_out >= 250) begin
				hold_done <= 1'b1;
				hold_left <= 300;
				rsp_ready <= 1'b0;
			end else begin
				case (rx_cycle[8:6])
					3'd0, 3'd1: rsp_ready <= 1'b1;
					3'd2: rsp_ready <= ($urandom_range(0, 1) == 0);
					3'd3: rsp_ready <= (rx_cycle[1:0] == 2'd0);
					3'd4: rsp_ready <= ($urandom_range(0, 9) != 0);
					3'd5: rsp_ready <= rx_cycle[3];
					default: rsp_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Monitor: checks each response transaction, then loads each seed and predicts each draw.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_samples_out <= n_samples_out + 1;
				if (pending_samples.size() == 0) begin
					report_mismatch("response with no draw outstanding");
				end else begin
					want = pending_samples.pop_front();
					if (rsp.sample !== want.sample)
						report_mismatch($sformatf("sample %0d, expected %0d",
							rsp.sample, want.sample));
					if (rsp.near_one !== want.near_one)
						report_mismatch($sformatf("near_one %b, expected %b",
							rsp.near_one, want.near_one));
				end
			end
			if (req_valid && req_ready) begin
				if (req.mode == MODE_SEED) begin
					gen1_mdl = longint'($signed(req.seed));
					n_seeds_in++;
				end else begin
					pending_samples.push_back(predict_draw());
					n_draws_in++;
				end
			end
			outstanding <= pending_samples.size();
		end
	end

	initial begin
		wait (arst_n);
		do
			@(negedge clk);
		while (stim_q.size() != 0 || req_valid || pending_samples.size() != 0);
		repeat (40) @(negedge clk);
		$display("Covered %0d draws with %0d table refills and %0d seed loads,",
			n_draws_in, n_refills, n_seeds_in);
		$display("under bursty requests, patterned response stalls and one long hold-off.");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d responses outstanding.", pending_samples.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
